@@ rtl/core/forth_stack_execution_unit_defines.svh @@
// assertion macros for the forth stack execution unit
`ifndef FORTH_STACK_EXECUTION_UNIT_DEFINES_SVH
`define FORTH_STACK_EXECUTION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FSEU_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("fseu assertion failed");
`define FSEU_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("fseu assertion failed");
`else
`define FSEU_ASSERT_IMP(lbl, pre, post)
`define FSEU_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ rtl/core/fseu_pkg.sv @@
package fseu_pkg;

    localparam int DATA_DEPTH   = 64;
    localparam int RETURN_DEPTH = 64;
    localparam int MEM_BYTES    = 4096;  // power of two

    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int DDW = $clog2(DATA_DEPTH + 1);
    localparam int RAW = $clog2(RETURN_DEPTH);
    localparam int RDW = $clog2(RETURN_DEPTH + 1);
    localparam int MAW = $clog2(MEM_BYTES);

    typedef enum logic [5:0] {
        CMD_LIT = 6'd0, CMD_ADD = 6'd1, CMD_SUB = 6'd2, CMD_MUL = 6'd3, CMD_DIV = 6'd4,
        CMD_MOD = 6'd5, CMD_NEG = 6'd6, CMD_AND = 6'd7, CMD_OR = 6'd8, CMD_XOR = 6'd9,
        CMD_INV = 6'd10, CMD_EQ = 6'd11, CMD_LT = 6'd12, CMD_GT = 6'd13, CMD_DUP = 6'd14,
        CMD_DROP = 6'd15, CMD_SWAP = 6'd16, CMD_OVER = 6'd17, CMD_ROT = 6'd18,
        CMD_TUCK = 6'd19, CMD_NIP = 6'd20, CMD_FETCH = 6'd21, CMD_STORE = 6'd22,
        CMD_CFETCH = 6'd23, CMD_CSTORE = 6'd24, CMD_DOT = 6'd25, CMD_LIST = 6'd26,
        CMD_CR = 6'd27, CMD_EMIT = 6'd28, CMD_SPACE = 6'd29, CMD_KEY = 6'd30,
        CMD_TOR = 6'd31, CMD_FROMR = 6'd32, CMD_RFETCH = 6'd33, CMD_ZBRANCH = 6'd34,
        CMD_CALL = 6'd35, CMD_EXIT = 6'd36
    } t_cmd;

    localparam logic [2:0] KIND_DONE   = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_CHAR   = 3'd2;
    localparam logic [2:0] KIND_LIST   = 3'd3;
    localparam logic [2:0] KIND_RETVAL = 3'd4;
    localparam logic [2:0] KIND_BRANCH = 3'd5;

    localparam logic [15:0] CHAR_NL   = 16'd10;
    localparam logic [15:0] CHAR_SP   = 16'd32;
    localparam logic [15:0] FLAG_TRUE = 16'hFFFF;

    typedef struct packed {
        logic [5:0]         cmd;
        logic signed [15:0] operand;
    } t_in;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] value;
        logic               last;
        logic               underflow;
        logic               overflow;
        logic [6:0]         depth;
    } t_out;

    // number of data stack pops an operation makes
    function automatic logic [1:0] pop_count(input logic [5:0] cmd);
        logic [1:0] n;
        begin
            unique case (cmd) inside
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_AND, CMD_OR, CMD_XOR,
                CMD_EQ, CMD_LT, CMD_GT, CMD_SWAP, CMD_OVER, CMD_TUCK, CMD_NIP,
                CMD_STORE, CMD_CSTORE: n = 2'd2;
                CMD_NEG, CMD_INV, CMD_DUP, CMD_DROP, CMD_FETCH, CMD_CFETCH, CMD_DOT,
                CMD_EMIT, CMD_TOR, CMD_ZBRANCH: n = 2'd1;
                CMD_ROT: n = 2'd3;
                default: n = 2'd0;
            endcase
            pop_count = n;
        end
    endfunction

endpackage

@@ rtl/core/forth_stack_execution_unit.sv @@
// forth stack execution unit
// input channel: i_in_valid / o_in_ready carry one item {cmd, operand}; each item
// runs one forth primitive against a data stack, a return stack and a byte memory
// output channel: o_out_valid / i_out_ready carry result items {kind, value, last,
// underflow, overflow, depth}; every item gives at least one result, the final one
// has last set, a stack listing gives one result per stack cell bottom first
// items are handled one at a time by a sequencer around memories with registered
// reads: the byte memory has a single port, each stack a read and a write port;
// each stack pop and each byte fetch waits for the registered read, a 16-bit
// fetch or store takes two byte accesses, and div and mod run a radix-2 divider
// after reset the byte memory is swept to zero, one byte per cycle, over all
// MEM_BYTES (4096) bytes; no item is accepted during the sweep
// a new item is accepted while the last result still waits in the output
// register; when the receiver stalls, the unit holds before loading the next result
module forth_stack_execution_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fseu_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output fseu_pkg::t_out  o_out_data
);

`include "forth_stack_execution_unit_defines.svh"

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DPOP, ST_DPOPW, ST_RPOP, ST_RPOPW, ST_MEM, ST_MEMW,
        ST_DIV, ST_EXEC, ST_PUSH, ST_LIST, ST_LISTW, ST_EMIT
    } t_state;

    t_state                       r_state;
    logic [5:0]                   r_cmd;
    logic [15:0]                  r_opnd;
    logic [15:0]                  r_p [3];      // popped cells, first popped at 0
    logic [1:0]                   r_pidx;
    logic [1:0]                   r_npop;
    logic [15:0]                  r_rv;         // value from the return stack
    logic [7:0]                   r_lo;
    logic [7:0]                   r_hi;
    logic                         r_mstep;
    logic [15:0]                  r_rem;
    logic [15:0]                  r_quo;
    logic [15:0]                  r_dvs;
    logic [3:0]                   r_dcnt;
    logic [15:0]                  r_q [3];      // cells to push, in order
    logic [1:0]                   r_nq;
    logic [1:0]                   r_qi;
    logic [2:0]                   r_okind;
    logic [15:0]                  r_oval;
    logic                         r_under;
    logic                         r_over;
    logic [fseu_pkg::DDW-1:0]     r_ddep;
    logic [fseu_pkg::RDW-1:0]     r_rdep;
    logic [fseu_pkg::DAW-1:0]     r_li;
    logic [fseu_pkg::MAW-1:0]     r_caddr;
    logic                         r_ov;
    fseu_pkg::t_out               r_out;

    // memories
    logic [15:0] r_dstk [fseu_pkg::DATA_DEPTH];
    logic [15:0] r_rstk [fseu_pkg::RETURN_DEPTH];
    logic [7:0]  r_dmem [fseu_pkg::MEM_BYTES];
    logic [15:0] r_ds_rd;
    logic [15:0] r_rs_rd;
    logic [7:0]  r_dm_rd;

    logic                       ds_we;
    logic [fseu_pkg::DAW-1:0]   ds_wa;
    logic [fseu_pkg::DAW-1:0]   ds_ra;
    logic                       rs_we;
    logic [fseu_pkg::RAW-1:0]   rs_wa;
    logic [fseu_pkg::RAW-1:0]   rs_ra;
    logic [15:0]                rs_wd;
    logic                       dm_we;
    logic [fseu_pkg::MAW-1:0]   dm_a;
    logic [7:0]                 dm_wd;

    logic [fseu_pkg::DDW-1:0]   ddep_m1;
    logic [fseu_pkg::RDW-1:0]   rdep_m1;
    logic                       out_free;
    logic                       list_last;

    // execute stage results
    logic [15:0] e_q [3];
    logic [1:0]  e_nq;
    logic [2:0]  e_okind;
    logic [15:0] e_oval;
    logic        e_rpush;
    logic [15:0] e_rval;
    logic [31:0] prod;
    logic [15:0] quo_s;
    logic [15:0] rem_s;
    logic [16:0] div_sh;
    logic [17:0] div_trial;

    assign ddep_m1   = r_ddep - 1'b1;
    assign rdep_m1   = r_rdep - 1'b1;
    assign out_free  = !r_ov || i_out_ready;
    assign list_last = (fseu_pkg::DDW'(r_li) + 1'b1) == r_ddep;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // memory port control
    always_comb begin
        ds_we = 1'b0;
        ds_wa = r_ddep[fseu_pkg::DAW-1:0];
        ds_ra = (r_state == ST_LIST) ? r_li : ddep_m1[fseu_pkg::DAW-1:0];
        rs_we = 1'b0;
        rs_wa = r_rdep[fseu_pkg::RAW-1:0];
        rs_ra = rdep_m1[fseu_pkg::RAW-1:0];
        rs_wd = e_rval;
        dm_we = 1'b0;
        dm_a  = r_p[0][fseu_pkg::MAW-1:0] + fseu_pkg::MAW'(r_mstep);
        dm_wd = r_mstep ? r_p[1][15:8] : r_p[1][7:0];
        if (r_state == ST_CLEAR) begin
            dm_we = 1'b1;
            dm_a  = r_caddr;
            dm_wd = 8'd0;
        end
        if (r_state == ST_MEM && (r_cmd == fseu_pkg::CMD_STORE ||
                                  r_cmd == fseu_pkg::CMD_CSTORE)) begin
            dm_we = 1'b1;
        end
        if (r_state == ST_PUSH && r_qi != r_nq &&
            r_ddep < fseu_pkg::DDW'(fseu_pkg::DATA_DEPTH)) begin
            ds_we = 1'b1;
        end
        if (r_state == ST_EXEC && e_rpush &&
            r_rdep < fseu_pkg::RDW'(fseu_pkg::RETURN_DEPTH)) begin
            rs_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ds_we) begin
            r_dstk[ds_wa] <= r_q[r_qi];
        end
        r_ds_rd <= r_dstk[ds_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            r_rstk[rs_wa] <= rs_wd;
        end
        r_rs_rd <= r_rstk[rs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dmem[dm_a] <= dm_wd;
        end
        r_dm_rd <= r_dmem[dm_a];
    end

    // one radix-2 divider step on magnitudes
    assign div_sh    = {r_rem, r_quo[15]};
    assign div_trial = {1'b0, div_sh} - {2'b00, r_dvs};

    assign prod  = r_p[1] * r_p[0];
    assign quo_s = (r_p[1][15] ^ r_p[0][15]) ? 16'(-r_quo) : r_quo;
    assign rem_s = r_p[1][15] ? 16'(-r_rem) : r_rem;

    // operation results: b = top popped, a = next
    always_comb begin
        e_q[0]  = 16'd0;
        e_q[1]  = 16'd0;
        e_q[2]  = 16'd0;
        e_nq    = 2'd1;
        e_okind = fseu_pkg::KIND_DONE;
        e_oval  = 16'd0;
        e_rpush = 1'b0;
        e_rval  = r_p[0];
        case (r_cmd) inside
            fseu_pkg::CMD_LIT:    e_q[0] = r_opnd;
            fseu_pkg::CMD_ADD:    e_q[0] = r_p[1] + r_p[0];
            fseu_pkg::CMD_SUB:    e_q[0] = r_p[1] - r_p[0];
            fseu_pkg::CMD_MUL:    e_q[0] = prod[15:0];
            fseu_pkg::CMD_DIV:    e_q[0] = (r_p[0] == 16'd0) ? 16'd0 : quo_s;
            fseu_pkg::CMD_MOD:    e_q[0] = (r_p[0] == 16'd0) ? 16'd0 : rem_s;
            fseu_pkg::CMD_NEG:    e_q[0] = 16'(-r_p[0]);
            fseu_pkg::CMD_AND:    e_q[0] = r_p[1] & r_p[0];
            fseu_pkg::CMD_OR:     e_q[0] = r_p[1] | r_p[0];
            fseu_pkg::CMD_XOR:    e_q[0] = r_p[1] ^ r_p[0];
            fseu_pkg::CMD_INV:    e_q[0] = ~r_p[0];
            fseu_pkg::CMD_EQ:     e_q[0] = (r_p[1] == r_p[0]) ? fseu_pkg::FLAG_TRUE : 16'd0;
            fseu_pkg::CMD_LT:     e_q[0] = ($signed(r_p[1]) < $signed(r_p[0])) ?
                                           fseu_pkg::FLAG_TRUE : 16'd0;
            fseu_pkg::CMD_GT:     e_q[0] = ($signed(r_p[1]) > $signed(r_p[0])) ?
                                           fseu_pkg::FLAG_TRUE : 16'd0;
            fseu_pkg::CMD_DUP: begin
                e_q[0] = r_p[0];
                e_q[1] = r_p[0];
                e_nq   = 2'd2;
            end
            fseu_pkg::CMD_SWAP: begin
                e_q[0] = r_p[0];
                e_q[1] = r_p[1];
                e_nq   = 2'd2;
            end
            fseu_pkg::CMD_OVER: begin
                e_q[0] = r_p[1];
                e_q[1] = r_p[0];
                e_q[2] = r_p[1];
                e_nq   = 2'd3;
            end
            fseu_pkg::CMD_ROT: begin
                e_q[0] = r_p[1];
                e_q[1] = r_p[0];
                e_q[2] = r_p[2];
                e_nq   = 2'd3;
            end
            fseu_pkg::CMD_TUCK: begin
                e_q[0] = r_p[0];
                e_q[1] = r_p[1];
                e_q[2] = r_p[0];
                e_nq   = 2'd3;
            end
            fseu_pkg::CMD_NIP:    e_q[0] = r_p[0];
            fseu_pkg::CMD_FETCH:  e_q[0] = {r_hi, r_lo};
            fseu_pkg::CMD_CFETCH: e_q[0] = {8'd0, r_lo};
            fseu_pkg::CMD_DOT: begin
                e_nq    = 2'd0;
                e_okind = fseu_pkg::KIND_NUMBER;
                e_oval  = r_p[0];
            end
            fseu_pkg::CMD_CR: begin
                e_nq    = 2'd0;
                e_okind = fseu_pkg::KIND_CHAR;
                e_oval  = fseu_pkg::CHAR_NL;
            end
            fseu_pkg::CMD_EMIT: begin
                e_nq    = 2'd0;
                e_okind = fseu_pkg::KIND_CHAR;
                e_oval  = {8'd0, r_p[0][7:0]};
            end
            fseu_pkg::CMD_SPACE: begin
                e_nq    = 2'd0;
                e_okind = fseu_pkg::KIND_CHAR;
                e_oval  = fseu_pkg::CHAR_SP;
            end
            fseu_pkg::CMD_KEY:    e_q[0] = 16'd0;
            fseu_pkg::CMD_TOR: begin
                e_nq    = 2'd0;
                e_rpush = 1'b1;
            end
            fseu_pkg::CMD_FROMR,
            fseu_pkg::CMD_RFETCH: e_q[0] = r_rv;
            fseu_pkg::CMD_ZBRANCH: begin
                e_nq    = 2'd0;
                e_okind = fseu_pkg::KIND_BRANCH;
                e_oval  = (r_p[0] == 16'd0) ? 16'd1 : 16'd0;
            end
            fseu_pkg::CMD_CALL: begin
                e_nq    = 2'd0;
                e_rpush = 1'b1;
                e_rval  = r_opnd;
            end
            fseu_pkg::CMD_EXIT: begin
                e_nq    = 2'd0;
                e_okind = fseu_pkg::KIND_RETVAL;
                e_oval  = r_rv;
            end
            default:              e_nq = 2'd0;   // drop, stores, listing, unknown codes
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_caddr <= '0;
            r_ddep  <= '0;
            r_rdep  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // the emit state reloads the output register itself
            if (r_ov && i_out_ready && r_state != ST_EMIT) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_caddr <= r_caddr + 1'b1;
                    if (r_caddr == fseu_pkg::MAW'(fseu_pkg::MEM_BYTES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_in_data.cmd;
                        r_opnd  <= i_in_data.operand;
                        r_under <= 1'b0;
                        r_over  <= 1'b0;
                        r_npop  <= fseu_pkg::pop_count(i_in_data.cmd);
                        r_pidx  <= 2'd0;
                        r_mstep <= 1'b0;
                        r_qi    <= 2'd0;
                        r_state <= ST_DPOP;
                    end
                end
                ST_DPOP: begin
                    if (r_npop == 2'd0) begin
                        // divider setup on magnitudes, a = dividend, b = divisor
                        r_quo  <= r_p[1][15] ? 16'(-r_p[1]) : r_p[1];
                        r_dvs  <= r_p[0][15] ? 16'(-r_p[0]) : r_p[0];
                        r_rem  <= 16'd0;
                        r_dcnt <= 4'd15;
                        case (r_cmd) inside
                            fseu_pkg::CMD_FROMR, fseu_pkg::CMD_RFETCH,
                            fseu_pkg::CMD_EXIT:  r_state <= ST_RPOP;
                            fseu_pkg::CMD_FETCH, fseu_pkg::CMD_STORE,
                            fseu_pkg::CMD_CFETCH,
                            fseu_pkg::CMD_CSTORE: r_state <= ST_MEM;
                            fseu_pkg::CMD_DIV,
                            fseu_pkg::CMD_MOD:   r_state <= ST_DIV;
                            default:             r_state <= ST_EXEC;
                        endcase
                    end else if (r_ddep == '0) begin
                        r_p[r_pidx] <= 16'd0;
                        r_under     <= 1'b1;
                        r_pidx      <= r_pidx + 1'b1;
                        r_npop      <= r_npop - 1'b1;
                    end else begin
                        r_ddep  <= ddep_m1;
                        r_state <= ST_DPOPW;
                    end
                end
                ST_DPOPW: begin
                    r_p[r_pidx] <= r_ds_rd;
                    r_pidx      <= r_pidx + 1'b1;
                    r_npop      <= r_npop - 1'b1;
                    r_state     <= ST_DPOP;
                end
                ST_RPOP: begin
                    if (r_rdep == '0) begin
                        r_rv    <= 16'd0;
                        r_under <= 1'b1;
                        r_state <= ST_EXEC;
                    end else begin
                        // return-fetch reads the top without popping
                        if (r_cmd != fseu_pkg::CMD_RFETCH) begin
                            r_rdep <= rdep_m1;
                        end
                        r_state <= ST_RPOPW;
                    end
                end
                ST_RPOPW: begin
                    r_rv    <= r_rs_rd;
                    r_state <= ST_EXEC;
                end
                ST_MEM: begin
                    if (r_cmd == fseu_pkg::CMD_STORE || r_cmd == fseu_pkg::CMD_CSTORE) begin
                        if (r_cmd == fseu_pkg::CMD_CSTORE || r_mstep) begin
                            r_state <= ST_EXEC;
                        end else begin
                            r_mstep <= 1'b1;
                        end
                    end else begin
                        r_state <= ST_MEMW;
                    end
                end
                ST_MEMW: begin
                    if (r_mstep) begin
                        r_hi <= r_dm_rd;
                    end else begin
                        r_lo <= r_dm_rd;
                    end
                    if (r_cmd == fseu_pkg::CMD_CFETCH || r_mstep) begin
                        r_state <= ST_EXEC;
                    end else begin
                        r_mstep <= 1'b1;
                        r_state <= ST_MEM;
                    end
                end
                ST_DIV: begin
                    if (!div_trial[17]) begin
                        r_rem <= div_trial[15:0];
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= div_sh[15:0];
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == 4'd0) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_q[0]  <= e_q[0];
                    r_q[1]  <= e_q[1];
                    r_q[2]  <= e_q[2];
                    r_nq    <= e_nq;
                    r_okind <= e_okind;
                    r_oval  <= e_oval;
                    if (e_rpush) begin
                        if (r_rdep < fseu_pkg::RDW'(fseu_pkg::RETURN_DEPTH)) begin
                            r_rdep <= r_rdep + 1'b1;
                        end else begin
                            r_over <= 1'b1;
                        end
                    end
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (r_qi == r_nq) begin
                        r_li <= '0;
                        if (r_cmd == fseu_pkg::CMD_LIST && r_ddep != '0) begin
                            r_state <= ST_LIST;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end else begin
                        if (r_ddep < fseu_pkg::DDW'(fseu_pkg::DATA_DEPTH)) begin
                            r_ddep <= r_ddep + 1'b1;
                        end else begin
                            r_over <= 1'b1;
                        end
                        r_qi <= r_qi + 1'b1;
                    end
                end
                ST_LIST: begin
                    // read only into an empty output register
                    if (!r_ov) begin
                        r_state <= ST_LISTW;
                    end
                end
                ST_LISTW: begin
                    r_out.kind      <= fseu_pkg::KIND_LIST;
                    r_out.value     <= r_ds_rd;
                    r_out.last      <= list_last;
                    r_out.underflow <= r_under;
                    r_out.overflow  <= r_over;
                    r_out.depth     <= 7'(r_ddep);
                    r_ov            <= 1'b1;
                    if (list_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_li    <= r_li + 1'b1;
                        r_state <= ST_LIST;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out.kind      <= r_okind;
                        r_out.value     <= r_oval;
                        r_out.last      <= 1'b1;
                        r_out.underflow <= r_under;
                        r_out.overflow  <= r_over;
                        r_out.depth     <= 7'(r_ddep);
                        r_ov            <= 1'b1;
                        r_state         <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // stack depths stay within their memories
    `FSEU_ASSERT_IMP(a_ddep_range, 1'b1, r_ddep <= fseu_pkg::DDW'(fseu_pkg::DATA_DEPTH))
    `FSEU_ASSERT_IMP(a_rdep_range, 1'b1, r_rdep <= fseu_pkg::RDW'(fseu_pkg::RETURN_DEPTH))
    // a listing read never goes past the top of the stack
    `FSEU_ASSERT_IMP(a_list_idx, r_state == ST_LISTW, fseu_pkg::DDW'(r_li) < r_ddep)
    // an accepted item always leaves idle
    `FSEU_ASSERT_NEXT(a_accept_busy, i_in_valid && o_in_ready, r_state == ST_DPOP)

endmodule
